// ===== rtl/cfr_pkg.sv =====
// Shared types and constants for the clock frame replacement block.
package cfr_pkg;

    localparam int POOL_W         = 7;
    localparam int FRAME_W        = 6;
    localparam int DEF_MAX_FRAMES = 64;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [POOL_W-1:0] POOL_RESET = 7'd64;

    // Register index, taken from paddr above the byte offset.
    localparam logic [PADDR_W-3:0] REG_POOL_FRAMES = 1'b0;

    localparam logic OP_ACCESS  = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_PUSH
    } cfr_state_t;

    typedef struct packed {
        logic access_wr;
        logic fresh;
        logic sweep_start;
        logic sweep_chk;
        logic out_load;
    } cfr_cmd_t;

    typedef struct packed {
        logic is_fresh;
        logic bit_set;
        logic last;
        logic out_free;
    } cfr_status_t;

endpackage

// ===== rtl/cfr_datapath.sv =====
// Datapath: accessed-bit memory, frame count, clock hand, sweep pointer and output register.
module cfr_datapath #(
    parameter int MAX_FRAMES = cfr_pkg::DEF_MAX_FRAMES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cfr_pkg::cfr_cmd_t           cmd,
    output cfr_pkg::cfr_status_t        status,
    input  logic [cfr_pkg::FRAME_W-1:0] s_frame_index,
    input  logic [cfr_pkg::POOL_W-1:0]  pool_frames,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [cfr_pkg::FRAME_W-1:0] m_granted_frame,
    output logic                        m_evicted
);
    import cfr_pkg::*;

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int XW = (CW > FRAME_W) ? CW : FRAME_W;

    logic          mem [MAX_FRAMES];
    logic          rd_bit_reg;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic          mem_wd;

    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      hand_reg, hand_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [IW-1:0]      res_frame_reg, res_frame_next;
    logic               res_evict_reg, res_evict_next;
    logic               m_valid_reg, m_valid_next;
    logic [FRAME_W-1:0] m_frame_reg, m_frame_next;
    logic               m_evict_reg, m_evict_next;
    logic [CW-1:0]      eff_pool;
    logic [CW-1:0]      idx_inc;
    logic               last;

    always_comb begin
        if (pool_frames == '0) begin
            eff_pool = CW'(1);
        end else if (int'(pool_frames) > MAX_FRAMES) begin
            eff_pool = CW'(MAX_FRAMES);
        end else begin
            eff_pool = CW'(pool_frames);
        end
    end

    assign idx_inc = CW'(idx_reg) + CW'(1);
    assign last    = (CW'(k_reg) + CW'(1)) == count_reg;

    assign status.is_fresh = count_reg < eff_pool;
    assign status.bit_set  = rd_bit_reg;
    assign status.last     = last;
    assign status.out_free = !m_valid_reg || m_ready;

    always_comb begin
        count_next     = count_reg;
        hand_next      = hand_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        res_frame_next = res_frame_reg;
        res_evict_next = res_evict_reg;
        m_valid_next   = m_valid_reg;
        m_frame_next   = m_frame_reg;
        m_evict_next   = m_evict_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg;
        mem_wd         = 1'b0;

        // Frames at or beyond the count are not in use, so their bits are never set.
        if (cmd.access_wr && (XW'(s_frame_index) < XW'(count_reg))) begin
            mem_we = 1'b1;
            mem_wa = IW'(s_frame_index);
            mem_wd = 1'b1;
        end

        // A fresh frame gets its bit cleared as it comes into use.
        if (cmd.fresh) begin
            mem_we         = 1'b1;
            mem_wa         = IW'(count_reg);
            mem_wd         = 1'b0;
            res_frame_next = IW'(count_reg);
            res_evict_next = 1'b0;
            count_next     = count_reg + CW'(1);
        end

        if (cmd.sweep_start) begin
            idx_next       = (CW'(hand_reg) >= count_reg) ? '0 : hand_reg;
            k_next         = '0;
            res_evict_next = 1'b1;
        end

        if (cmd.sweep_chk) begin
            if (rd_bit_reg) begin
                mem_we   = 1'b1;
                mem_wa   = idx_reg;
                mem_wd   = 1'b0;
                k_next   = k_reg + IW'(1);
                idx_next = (idx_inc >= count_reg) ? '0 : IW'(idx_inc);
                if (last) begin
                    // Every frame was accessed: the one just before the hand goes.
                    res_frame_next = (hand_reg == '0) ? IW'(count_reg - CW'(1))
                                                      : hand_reg - IW'(1);
                end
            end else begin
                hand_next      = idx_reg;
                res_frame_next = idx_reg;
            end
        end

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            m_frame_next = FRAME_W'(res_frame_reg);
            m_evict_next = res_evict_reg;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_bit_reg <= mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            hand_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            hand_reg    <= hand_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        res_frame_reg <= res_frame_next;
        res_evict_reg <= res_evict_next;
        m_frame_reg   <= m_frame_next;
        m_evict_reg   <= m_evict_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_frame = m_frame_reg;
    assign m_evicted       = m_evict_reg;

endmodule

// ===== rtl/cfr_controller.sv =====
// Controller state machine: sequences access updates, fresh grants and victim sweeps.
module cfr_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_op,
    output logic                 s_ready,
    input  cfr_pkg::cfr_status_t status,
    output cfr_pkg::cfr_cmd_t    cmd
);
    import cfr_pkg::*;

    cfr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == OP_ACCESS) begin
                        cmd.access_wr = 1'b1;
                    end else if (status.is_fresh) begin
                        cmd.fresh  = 1'b1;
                        state_next = ST_PUSH;
                    end else begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.sweep_chk = 1'b1;
                if (!status.bit_set || status.last) begin
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_PUSH: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/clock_frame_replacement.sv =====
// Top level of the clock (second-chance) frame allocator.
//
// Input channel (s_valid/s_ready, s_op, s_frame_index): an access transfer
// (s_op = 0) marks a frame in use as accessed; it gives no result. A
// request transfer (s_op = 1) gives one result on the m_ channel: the
// granted frame and whether it was taken from a victim. A fresh grant
// passes through ST_PUSH and is loaded into the output register once the
// register is free. A sweep reads one accessed bit from the bit memory
// at a time (memory read in ST_READ, then check and clear in ST_CHECK),
// then loads its evicting result through ST_PUSH; it examines at most
// the number of frames in use. The next transfer can follow the load.
// The block works on one request at a time and takes no input while a
// sweep runs.
// The output register lets the next access transfer in while a result
// waits; a request that finishes while the receiver stalls holds its
// result until the register frees up.
// The user writes pool_frames at APB address 0 only when idle; not enforced.
// Reset empties the pool and parks the hand at frame 0; the bit memory
// needs no clearing pass, as a frame's bit is cleared when it is granted.
module clock_frame_replacement #(
    parameter int MAX_FRAMES = cfr_pkg::DEF_MAX_FRAMES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [cfr_pkg::FRAME_W-1:0] s_frame_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [cfr_pkg::FRAME_W-1:0] m_granted_frame,
    output logic                        m_evicted,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfr_pkg::PADDR_W-1:0] paddr,
    input  logic [cfr_pkg::PDATA_W-1:0] pwdata,
    output logic [cfr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import cfr_pkg::*;

    cfr_cmd_t          cmd;
    cfr_status_t       status;
    logic [POOL_W-1:0] pool_reg, pool_next;
    logic              reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = paddr[PADDR_W-1:2] == REG_POOL_FRAMES;

    always_comb begin
        pool_next = pool_reg;
        if (psel && penable && pwrite && reg_hit) begin
            pool_next = pwdata[POOL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_reg <= POOL_RESET;
        end else begin
            pool_reg <= pool_next;
        end
    end

    assign prdata = reg_hit ? {{(PDATA_W-POOL_W){1'b0}}, pool_reg} : '0;

    cfr_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_op),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cfr_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_frame_index   (s_frame_index),
        .pool_frames     (pool_reg),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_granted_frame (m_granted_frame),
        .m_evicted       (m_evicted)
    );

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.access_wr, cmd.fresh, cmd.sweep_start, cmd.sweep_chk, cmd.out_load}))
        else $error("more than one datapath command in a cycle");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register loaded while a result still waits");

    a_req_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_REQUEST) |=> !s_ready)
        else $error("input taken while a request is still in progress");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("result not presented after the output register load");

endmodule
